/* rtl/ste_pkg.sv */
package ste_pkg;

  localparam int POS_W   = 24;
  localparam int COEF_W  = 32;
  localparam int PROD_W  = POS_W + COEF_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int ACC_W   = 48;
  localparam int OFF_SH  = 8;
  localparam int CELL_SH = 28;
  localparam int CELL_W  = ACC_W - CELL_SH;
  localparam int TEX_W   = 24;
  localparam int EXT_W   = 25;
  localparam int IDX_W   = 3;

  localparam logic signed [ACC_W-1:0] SENT_MIN = 48'sd16777199222784;
  localparam logic signed [ACC_W-1:0] SENT_MAX = -48'sd1677704822784;
  localparam logic signed [EXT_W:0]   EXT_SAT  = 26'sd16777200;

  typedef enum logic [IDX_W-1:0] {
    REG_VEC_S_X   = 3'd0,
    REG_VEC_S_Y   = 3'd1,
    REG_VEC_S_Z   = 3'd2,
    REG_VEC_S_OFF = 3'd3,
    REG_VEC_T_X   = 3'd4,
    REG_VEC_T_Y   = 3'd5,
    REG_VEC_T_Z   = 3'd6,
    REG_VEC_T_OFF = 3'd7
  } cfg_reg_e;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef struct packed {
    coef_t x;
    coef_t y;
    coef_t z;
    coef_t off;
  } axis_cfg_t;

  // Pipeline enables handed from the top-level flow control to each axis.
  typedef struct packed {
    logic ld_prod;
    logic ld_proj;
    logic upd;
    logic last;
    logic out_ld;
  } pipe_ctrl_t;

endpackage

/* rtl/ste_cfg.sv */
module ste_cfg
  import ste_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [COEF_W-1:0] cfg_data,
  output axis_cfg_t         s_axis,
  output axis_cfg_t         t_axis
);

  cfg_reg_e idx;

  assign idx = cfg_reg_e'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      s_axis <= '0;
      t_axis <= '0;
    end else if (cfg_wr_en) begin
      case (idx)
        REG_VEC_S_X:   s_axis.x   <= coef_t'(cfg_data);
        REG_VEC_S_Y:   s_axis.y   <= coef_t'(cfg_data);
        REG_VEC_S_Z:   s_axis.z   <= coef_t'(cfg_data);
        REG_VEC_S_OFF: s_axis.off <= coef_t'(cfg_data);
        REG_VEC_T_X:   t_axis.x   <= coef_t'(cfg_data);
        REG_VEC_T_Y:   t_axis.y   <= coef_t'(cfg_data);
        REG_VEC_T_Z:   t_axis.z   <= coef_t'(cfg_data);
        REG_VEC_T_OFF: t_axis.off <= coef_t'(cfg_data);
        default: ;
      endcase
    end
  end

endmodule

/* rtl/ste_project.sv */
module ste_project
  import ste_pkg::*;
(
  input  logic       clk,
  input  pipe_ctrl_t ctrl,
  input  axis_cfg_t  axis,
  input  pos_t       pos_x,
  input  pos_t       pos_y,
  input  pos_t       pos_z,
  output acc_t       proj
);

  logic signed [PROD_W-1:0] mul_x, mul_y, mul_z;
  logic signed [PROD_W-1:0] prod_x, prod_y, prod_z;
  coef_t                    off_q;
  logic signed [SUM_W-1:0]  sum;
  logic                     sum_ovf;
  acc_t                     sat;

  // Both operands are signed, so they sign-extend to the product width.
  assign mul_x = pos_x * axis.x;
  assign mul_y = pos_y * axis.y;
  assign mul_z = pos_z * axis.z;

  always_ff @(posedge clk) begin
    if (ctrl.ld_prod) begin
      prod_x <= mul_x;
      prod_y <= mul_y;
      prod_z <= mul_z;
      off_q  <= axis.off;
    end
  end

  assign sum = SUM_W'(prod_x) + SUM_W'(prod_y) + SUM_W'(prod_z)
             + (SUM_W'(off_q) <<< OFF_SH);

  // The sum fits the tracker width only when all bits above its sign agree.
  assign sum_ovf = (sum[SUM_W-1:ACC_W-1] != '0) && (sum[SUM_W-1:ACC_W-1] != '1);

  always_comb begin
    if (!sum_ovf) begin
      sat = sum[ACC_W-1:0];
    end else if (sum[SUM_W-1]) begin
      sat = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_proj) begin
      proj <= sat;
    end
  end

endmodule

/* rtl/ste_track.sv */
module ste_track
  import ste_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  pipe_ctrl_t              ctrl,
  input  acc_t                    proj,
  output logic signed [TEX_W-1:0] texmin,
  output logic signed [EXT_W-1:0] extent
);

  acc_t                      min_acc, max_acc;
  acc_t                      min_new, max_new;
  acc_t                      fin_min, fin_max;
  logic signed [CELL_W-1:0]  lo;
  logic signed [ACC_W:0]     max_up;
  logic signed [CELL_W:0]    hi;
  logic signed [CELL_W+1:0]  span;
  logic signed [EXT_W:0]     ext_full;
  logic signed [EXT_W-1:0]   ext_sat;

  assign min_new = (proj < min_acc) ? proj : min_acc;
  assign max_new = (proj > max_acc) ? proj : max_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_acc <= SENT_MIN;
      max_acc <= SENT_MAX;
    end else if (ctrl.upd) begin
      if (ctrl.last) begin
        min_acc <= SENT_MIN;
        max_acc <= SENT_MAX;
      end else begin
        min_acc <= min_new;
        max_acc <= max_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.upd && ctrl.last) begin
      fin_min <= min_new;
      fin_max <= max_new;
    end
  end

  // An arithmetic shift floors; adding one cell less one first ceils.
  assign lo       = CELL_W'(fin_min >>> CELL_SH);
  assign max_up   = (ACC_W+1)'(fin_max) + (ACC_W+1)'({CELL_SH{1'b1}});
  assign hi       = (CELL_W+1)'(max_up >>> CELL_SH);
  assign span     = (CELL_W+2)'(hi) - (CELL_W+2)'(lo);
  assign ext_full = (EXT_W+1)'(span) <<< 4;
  assign ext_sat  = (ext_full > EXT_SAT) ? EXT_W'(EXT_SAT) : EXT_W'(ext_full);

  always_ff @(posedge clk) begin
    if (ctrl.out_ld) begin
      texmin <= {lo, 4'b0000};
      extent <= ext_sat;
    end
  end

endmodule

/* rtl/surface_texture_extents.sv */
// Channel  Direction  Handshake              Payload
// in       sink       in_valid / in_stall    pos_x, pos_y, pos_z, last_vertex
// out      source     out_valid / out_stall  texmin_s, texmin_t, extent_s, extent_t
// cfg      sink       cfg_wr_en              cfg_index, cfg_data
//
// One vertex beat is taken every cycle unless in_stall is high; the pipeline is
// input register, products, projection sum with saturation, min/max trackers,
// and the output register, through which the last_vertex beat's result passes.
// Reset clears the axis registers to zero and the trackers to their sentinels.
// A stalled output blocks the pipeline only when two finished surfaces are already
// waiting and a third reaches the trackers; ordinary vertices keep flowing.
module surface_texture_extents
  import ste_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [COEF_W-1:0]       cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic                    last_vertex,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [TEX_W-1:0] texmin_s,
  output logic signed [TEX_W-1:0] texmin_t,
  output logic signed [EXT_W-1:0] extent_s,
  output logic signed [EXT_W-1:0] extent_t
);

  axis_cfg_t  s_axis, t_axis;
  pipe_ctrl_t ctrl;
  pos_t       px, py, pz;
  acc_t       proj_s, proj_t;
  logic       v1, v2, v3, l1, l2, l3, fv;
  logic       ofree, fin_free, take3, load1, load2, load3;

  ste_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_axis    (s_axis),
    .t_axis    (t_axis)
  );

  assign ofree    = !out_valid || !out_stall;
  assign fin_free = !fv || ofree;
  assign take3    = !l3 || fin_free;
  assign load3    = !v3 || take3;
  assign load2    = !v2 || load3;
  assign load1    = !v1 || load2;
  assign in_stall = !load1;

  assign ctrl.ld_prod = load2;
  assign ctrl.ld_proj = load3;
  assign ctrl.upd     = v3 && take3;
  assign ctrl.last    = l3;
  assign ctrl.out_ld  = ofree && fv;

  always_ff @(posedge clk) begin
    if (load1) begin
      px <= pos_x;
      py <= pos_y;
      pz <= pos_z;
      l1 <= last_vertex;
    end
    if (load2) begin
      l2 <= l1;
    end
    if (load3) begin
      l3 <= l2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      fv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load1) begin
        v1 <= in_valid;
      end
      if (load2) begin
        v2 <= v1;
      end
      if (load3) begin
        v3 <= v2;
      end
      if (ctrl.upd && l3) begin
        fv <= 1'b1;
      end else if (ofree) begin
        fv <= 1'b0;
      end
      if (ofree) begin
        out_valid <= fv;
      end
    end
  end

  ste_project u_proj_s (
    .clk   (clk),
    .ctrl  (ctrl),
    .axis  (s_axis),
    .pos_x (px),
    .pos_y (py),
    .pos_z (pz),
    .proj  (proj_s)
  );

  ste_project u_proj_t (
    .clk   (clk),
    .ctrl  (ctrl),
    .axis  (t_axis),
    .pos_x (px),
    .pos_y (py),
    .pos_z (pz),
    .proj  (proj_t)
  );

  ste_track u_track_s (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .proj   (proj_s),
    .texmin (texmin_s),
    .extent (extent_s)
  );

  ste_track u_track_t (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .proj   (proj_t),
    .texmin (texmin_t),
    .extent (extent_t)
  );

  // An accepted beat always lands in the input register.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> v1)
    else $error("accepted beat did not reach the input register");

  // A finished surface is never written over one still waiting for the output.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.upd && ctrl.last |-> fin_free)
    else $error("finished surface overwrote a pending result");

  // A last vertex that cannot finish stays at the trackers.
  a_last_held: assert property (@(posedge clk) disable iff (rst)
    v3 && l3 && !fin_free |=> v3 && l3)
    else $error("blocked last vertex left the tracker stage");

  // A result only appears after a finished surface was pending.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(fv))
    else $error("result raised without a finished surface");

endmodule
